// File: rtl/rrca_pkg.sv
// shared types and constants of the reorder receiver
`default_nettype none

package rrca_pkg;

  // field widths of the packet and result words
  localparam int ID_W     = 31;
  localparam int LEN_W    = 12;
  localparam int HANDLE_W = 16;
  localparam int KIND_W   = 2;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ACK     = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_FINISH  = 2'd2
  } kind_t;

  // one window slot as held in the slot memory
  typedef struct packed {
    logic                valid;
    logic [LEN_W-1:0]    len;
    logic [HANDLE_W-1:0] handle;
  } slot_entry_t;

  // receiver control states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_STORE_RD,
    S_STORE_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EMIT_ACK,
    S_DLV_FIRST,
    S_DLV_RD,
    S_DLV_OUT,
    S_EMIT_FIN
  } state_t;

endpackage

`default_nettype wire

// File: rtl/rrca_if.sv
// valid/ready channels for packet descriptor and result words
`default_nettype none

interface rrca_in_if import rrca_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     packet_id;
  logic [LEN_W-1:0]    payload_length;
  logic [HANDLE_W-1:0] buffer_handle;
  logic                empty_datagram;

  modport source (
    output valid, packet_id, payload_length, buffer_handle, empty_datagram,
    input  ready
  );
  modport sink (
    input  valid, packet_id, payload_length, buffer_handle, empty_datagram,
    output ready
  );
endinterface

interface rrca_out_if import rrca_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ID_W-1:0]     ack_number;
  logic [LEN_W-1:0]    out_length;
  logic [HANDLE_W-1:0] out_handle;
  logic                last;

  modport source (
    output valid, kind, ack_number, out_length, out_handle, last,
    input  ready
  );
  modport sink (
    input  valid, kind, ack_number, out_length, out_handle, last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/rrca_mod_unit.sv
// slot index of an arriving sequence number inside the receive window
`default_nettype none

module rrca_mod_unit import rrca_pkg::*; #(
  parameter int WINDOW = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [ID_W-1:0]           value,
  input  wire logic [ID_W-1:0]           offset,
  input  wire logic [$clog2(WINDOW)-1:0] base,
  output logic                           done,
  output logic [$clog2(WINDOW)-1:0]      rem
);

  localparam int RW = $clog2(WINDOW);
  localparam logic [RW:0] WIN_SIZE = (RW + 1)'(WINDOW);

  logic [RW:0]   sum;
  logic [RW:0]   diff;
  logic [RW-1:0] rem_next;

  // slot of the cumulative ack stepped forward by the offset, at most one wrap
  // only meaningful for an offset of 1 to WINDOW
  always_comb begin
    sum  = {1'b0, base} + offset[RW:0];
    diff = sum - WIN_SIZE;
    if (value < offset) begin
      // number wrapped past zero, so it is below WINDOW and is its own slot
      rem_next = value[RW-1:0];
    end else if (sum >= WIN_SIZE) begin
      rem_next = diff[RW-1:0];
    end else begin
      rem_next = sum[RW-1:0];
    end
  end

  // result valid the cycle after start
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // registered slot index
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/reorder_receiver_cumulative_ack_top.sv
// reorder receiver with cumulative ack: window slot memory and control
//
// Takes one packet descriptor at a time and answers with an ack word, a
// finish word, or an ack followed by the in-order run of delivered packets.
// All window slots live in one memory with a registered read, so each slot
// visit is a read state followed by a state that uses the read data. The
// slot of a packet is derived from the slot of the cumulative ack and the
// packet's offset from it. After reset a clearing pass empties the slots
// before the first packet is taken. Per packet: a packet after finish is
// taken and ignored, a finish, a dropped or a stored packet answers with one
// word, and an expected packet that releases a run of r packets answers with
// r + 1 words; the result side can stall any word.
`default_nettype none

module reorder_receiver_cumulative_ack_top import rrca_pkg::*; #(
  parameter int WINDOW      = 32,
  parameter int MAX_PAYLOAD = 2048
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rrca_in_if.sink    pkt,
  rrca_out_if.source result
);

  localparam int RW   = $clog2(WINDOW);
  localparam int RUNW = $clog2(WINDOW + 1);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  // slot memory
  slot_entry_t mem [WINDOW];
  slot_entry_t rd_data;
  logic        mem_re;
  logic        mem_we;
  logic [RW-1:0] mem_raddr;
  logic [RW-1:0] mem_waddr;
  slot_entry_t   mem_wdata;

  // control and packet registers
  state_t              state, state_next;
  logic [ID_W-1:0]     lio, lio_next;
  logic [RW-1:0]       lio_slot, lio_slot_next;
  logic                finished, finished_next;
  logic [ID_W-1:0]     pid, pid_next;
  logic [LEN_W-1:0]    len_r, len_next;
  logic [HANDLE_W-1:0] handle_r, handle_next;
  logic                off_one, off_one_next;
  logic                off_win, off_win_next;
  logic [RW-1:0]       pid_slot, pid_slot_next;
  logic [RW-1:0]       cur_slot, cur_slot_next;
  logic [ID_W-1:0]     cur_num, cur_num_next;
  logic [RUNW-1:0]     run, run_next;
  logic [RUNW-1:0]     cnt, cnt_next;
  logic [RW-1:0]       clr_addr, clr_addr_next;

  // output register
  logic                out_valid, out_valid_next;
  logic [KIND_W-1:0]   out_kind, out_kind_next;
  logic [ID_W-1:0]     out_ack, out_ack_next;
  logic [LEN_W-1:0]    out_len, out_len_next;
  logic [HANDLE_W-1:0] out_handle, out_handle_next;
  logic                out_last, out_last_next;
  logic                out_free;

  // remainder unit
  logic          mod_start;
  logic          mod_done;
  logic [RW-1:0] mod_rem;

  // packet classification at accept
  logic [ID_W-1:0]  offset;
  logic [LEN_W-1:0] len_clamped;

  rrca_mod_unit #(
    .WINDOW (WINDOW)
  ) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .value  (pid_next),
    .offset (offset),
    .base   (lio_slot),
    .done   (mod_done),
    .rem    (mod_rem)
  );

  // slot that follows, restarting at zero when the number wraps
  function automatic logic [RW-1:0] next_slot(input logic [RW-1:0] slot,
                                              input logic [ID_W-1:0] num_next);
    logic [RW-1:0] res;
    if (num_next == '0) begin
      res = '0;
    end else if (slot == RW'(WINDOW - 1)) begin
      res = '0;
    end else begin
      res = slot + 1'b1;
    end
    return res;
  endfunction

  assign offset      = pkt.packet_id - lio;
  assign len_clamped = ({4'b0, pkt.payload_length} > MAX_LEN) ? MAX_LEN[LEN_W-1:0]
                                                               : pkt.payload_length;
  assign out_free    = !out_valid || result.ready;

  assign pkt.ready         = (state == S_IDLE);
  assign result.valid      = out_valid;
  assign result.kind       = out_kind;
  assign result.ack_number = out_ack;
  assign result.out_length = out_len;
  assign result.out_handle = out_handle;
  assign result.last       = out_last;

  // next state and datapath control
  always_comb begin
    state_next      = state;
    lio_next        = lio;
    lio_slot_next   = lio_slot;
    finished_next   = finished;
    pid_next        = pid;
    len_next        = len_r;
    handle_next     = handle_r;
    off_one_next    = off_one;
    off_win_next    = off_win;
    pid_slot_next   = pid_slot;
    cur_slot_next   = cur_slot;
    cur_num_next    = cur_num;
    run_next        = run;
    cnt_next        = cnt;
    clr_addr_next   = clr_addr;
    out_valid_next  = out_valid && !result.ready;
    out_kind_next   = out_kind;
    out_ack_next    = out_ack;
    out_len_next    = out_len;
    out_handle_next = out_handle;
    out_last_next   = out_last;
    mem_re          = 1'b0;
    mem_we          = 1'b0;
    mem_raddr       = cur_slot;
    mem_waddr       = cur_slot;
    mem_wdata       = '0;
    mod_start       = 1'b0;

    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == RW'(WINDOW - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end

      S_IDLE: begin
        if (pkt.valid && !finished) begin
          if (pkt.empty_datagram || pkt.packet_id == '0) begin
            finished_next = 1'b1;
            state_next    = S_EMIT_FIN;
          end else begin
            pid_next     = pkt.packet_id;
            len_next     = len_clamped;
            handle_next  = pkt.buffer_handle;
            off_one_next = (offset == ID_W'(1));
            off_win_next = (offset >= ID_W'(2)) && (offset <= ID_W'(WINDOW));
            mod_start    = 1'b1;
            state_next   = S_MOD;
          end
        end
      end

      S_MOD: begin
        if (mod_done) begin
          pid_slot_next = mod_rem;
          if (off_one) begin
            lio_next      = pid;
            lio_slot_next = mod_rem;
            run_next      = RUNW'(1);
            cur_num_next  = pid + 1'b1;
            cur_slot_next = next_slot(mod_rem, pid + 1'b1);
            state_next    = S_SCAN_RD;
          end else if (off_win) begin
            state_next = S_STORE_RD;
          end else begin
            state_next = S_EMIT_ACK;
          end
        end
      end

      S_STORE_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = pid_slot;
        state_next = S_STORE_WR;
      end

      S_STORE_WR: begin
        // a duplicate keeps the first copy
        if (!rd_data.valid) begin
          mem_we           = 1'b1;
          mem_waddr        = pid_slot;
          mem_wdata.valid  = 1'b1;
          mem_wdata.len    = len_r;
          mem_wdata.handle = handle_r;
        end
        state_next = S_EMIT_ACK;
      end

      S_SCAN_RD: begin
        mem_re     = 1'b1;
        state_next = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        // the expected packet's own slot counts as already released
        if (rd_data.valid && cur_slot != pid_slot) begin
          lio_next      = cur_num;
          lio_slot_next = cur_slot;
          run_next      = run + 1'b1;
          cur_num_next  = cur_num + 1'b1;
          cur_slot_next = next_slot(cur_slot, cur_num + 1'b1);
          if ((run + 1'b1) < RUNW'(WINDOW)) begin
            state_next = S_SCAN_RD;
          end else begin
            state_next = S_EMIT_ACK;
          end
        end else begin
          state_next = S_EMIT_ACK;
        end
      end

      S_EMIT_ACK: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_kind_next   = KIND_ACK;
          out_ack_next    = lio;
          out_len_next    = '0;
          out_handle_next = '0;
          out_last_next   = !off_one;
          state_next      = off_one ? S_DLV_FIRST : S_IDLE;
        end
      end

      S_DLV_FIRST: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_kind_next   = KIND_DELIVER;
          out_ack_next    = pid;
          out_len_next    = len_r;
          out_handle_next = handle_r;
          out_last_next   = (run == RUNW'(1));
          mem_we          = 1'b1;
          mem_waddr       = pid_slot;
          cur_num_next    = pid + 1'b1;
          cur_slot_next   = next_slot(pid_slot, pid + 1'b1);
          cnt_next        = RUNW'(1);
          state_next      = (run == RUNW'(1)) ? S_IDLE : S_DLV_RD;
        end
      end

      S_DLV_RD: begin
        mem_re     = 1'b1;
        state_next = S_DLV_OUT;
      end

      S_DLV_OUT: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          out_kind_next    = KIND_DELIVER;
          out_ack_next     = cur_num;
          out_len_next     = rd_data.len;
          out_handle_next  = rd_data.handle;
          out_last_next    = ((cnt + 1'b1) == run);
          // release clears only the valid bit, the descriptor stays
          mem_we           = 1'b1;
          mem_wdata.len    = rd_data.len;
          mem_wdata.handle = rd_data.handle;
          cur_num_next     = cur_num + 1'b1;
          cur_slot_next    = next_slot(cur_slot, cur_num + 1'b1);
          cnt_next         = cnt + 1'b1;
          state_next       = ((cnt + 1'b1) == run) ? S_IDLE : S_DLV_RD;
        end
      end

      S_EMIT_FIN: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_kind_next   = KIND_FINISH;
          out_ack_next    = lio;
          out_len_next    = '0;
          out_handle_next = '0;
          out_last_next   = 1'b1;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      lio       <= '0;
      lio_slot  <= '0;
      finished  <= 1'b0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      lio       <= lio_next;
      lio_slot  <= lio_slot_next;
      finished  <= finished_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
    end
  end

  // packet and result word registers
  always_ff @(posedge clk) begin
    pid        <= pid_next;
    len_r      <= len_next;
    handle_r   <= handle_next;
    off_one    <= off_one_next;
    off_win    <= off_win_next;
    pid_slot   <= pid_slot_next;
    cur_slot   <= cur_slot_next;
    cur_num    <= cur_num_next;
    run        <= run_next;
    cnt        <= cnt_next;
    out_kind   <= out_kind_next;
    out_ack    <= out_ack_next;
    out_len    <= out_len_next;
    out_handle <= out_handle_next;
    out_last   <= out_last_next;
  end

  // slot memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // slot memory read port, data held until the next read
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for the reorder receiver: packet driver, result monitor, window predictor
module tb_top;
  import rrca_pkg::*;

  localparam int unsigned WIN     = 32;
  localparam int unsigned MAX_LEN = 2048;
  localparam int NUM_PKTS         = 460;
  localparam int STALL_LIMIT      = 3000;
  localparam int DRAIN_CYCLES     = 60;

  // one packet descriptor as driven on the input channel
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [LEN_W-1:0]    len;
    logic [HANDLE_W-1:0] handle;
    logic                empty;
  } pkt_word_t;

  // one result word as seen on the output channel
  typedef struct packed {
    kind_t               kind;
    logic [ID_W-1:0]     ack_number;
    logic [LEN_W-1:0]    len;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } res_word_t;

  // receiver state: cumulative ack, held window slots, finish flag
  typedef struct packed {
    logic [ID_W-1:0]                in_order;
    logic [WIN-1:0]                 held;
    logic [WIN-1:0][LEN_W-1:0]      held_len;
    logic [WIN-1:0][HANDLE_W-1:0]   held_handle;
    logic                           finished;
  } rx_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rrca_in_if  pkt_if ();
  rrca_out_if res_if ();

  reorder_receiver_cumulative_ack_top #(
    .WINDOW      (WIN),
    .MAX_PAYLOAD (MAX_LEN)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .pkt    (pkt_if),
    .result (res_if)
  );

  pkt_word_t pending[$];
  res_word_t expected_words[$];
  rx_state_t rx_model;
  rx_state_t gen_model;
  pkt_word_t cur_pkt;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int n_total       = 0;
  int pkts_taken    = 0;
  int words_checked = 0;
  int n_errors      = 0;
  int n_acks        = 0;
  int n_delivers    = 0;
  int n_finishes    = 0;
  int longest_run   = 0;
  int idle_cycles   = 0;

  always #6 clk = ~clk;

  // record one expected result word
  function automatic void queue_word(input kind_t k, input logic [ID_W-1:0] num,
                                     input logic [LEN_W-1:0] len,
                                     input logic [HANDLE_W-1:0] handle, input logic lst);
    res_word_t w;
    w = '{kind: k, ack_number: num, len: len, handle: handle, last: lst};
    expected_words.push_back(w);
    case (k)
      KIND_ACK:     n_acks++;
      KIND_DELIVER: n_delivers++;
      default:      n_finishes++;
    endcase
  endfunction

  // advance the receiver by one packet; optionally record the words it causes
  function automatic void receive_packet(inout rx_state_t st, input pkt_word_t p,
                                         input bit record);
    logic [ID_W-1:0]  offset;
    logic [ID_W-1:0]  num;
    logic [LEN_W-1:0] len;
    int unsigned      run;
    int unsigned      s;
    int unsigned      n;
    if (st.finished) return;
    len = (p.len > MAX_LEN) ? LEN_W'(MAX_LEN) : p.len;
    // end of transfer
    if (p.empty || p.id == '0) begin
      st.finished = 1'b1;
      if (record) queue_word(KIND_FINISH, st.in_order, '0, '0, 1'b1);
      return;
    end
    offset = p.id - st.in_order;
    // expected packet: release it and the held run behind it
    if (offset == ID_W'(1)) begin
      st.held[p.id % WIN] = 1'b0;
      run = 1;
      while (run < WIN && st.held[ID_W'(p.id + run) % WIN]) run++;
      st.in_order = ID_W'(p.id + run - 1);
      if (record) begin
        queue_word(KIND_ACK, st.in_order, '0, '0, 1'b0);
        queue_word(KIND_DELIVER, p.id, len, p.handle, run == 1);
        if (int'(run) > longest_run) longest_run = run;
      end
      for (n = 1; n < run; n++) begin
        num = ID_W'(p.id + n);
        s = num % WIN;
        if (record) queue_word(KIND_DELIVER, num, st.held_len[s], st.held_handle[s], n + 1 == run);
        st.held[s] = 1'b0;
      end
      return;
    end
    // ahead inside the window: first copy wins
    if (offset >= 2 && offset <= WIN) begin
      s = p.id % WIN;
      if (!st.held[s]) begin
        st.held[s]        = 1'b1;
        st.held_len[s]    = len;
        st.held_handle[s] = p.handle;
      end
    end
    if (record) queue_word(KIND_ACK, st.in_order, '0, '0, 1'b1);
  endfunction

  // stimulus building, tracked against a separate copy of the receiver
  function automatic void add_pkt(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                                  input logic [HANDLE_W-1:0] handle, input logic empty);
    pkt_word_t p;
    p = '{id: id, len: len, handle: handle, empty: empty};
    pending.push_back(p);
    receive_packet(gen_model, p, 1'b0);
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return LEN_W'(MAX_LEN);
    if (r < 30) return LEN_W'($urandom_range(4095, MAX_LEN + 1));
    return LEN_W'($urandom_range(MAX_LEN));
  endfunction

  // packet behind the window, beyond it, or anywhere
  function automatic void add_noise();
    logic [ID_W-1:0] id;
    case ($urandom_range(2))
      0:       id = gen_model.in_order - ID_W'($urandom_range(40));
      1:       id = gen_model.in_order + ID_W'($urandom_range(2000, WIN + 1));
      default: id = ID_W'($urandom);
    endcase
    if (id == '0) id = gen_model.in_order + ID_W'(WIN + 1);
    add_pkt(id, rand_len(), HANDLE_W'($urandom), 1'b0);
  endfunction

  // shuffled run of k packets after the current ack, with stray dups and noise
  function automatic void add_burst(input int unsigned k, input bit one_last);
    logic [ID_W-1:0] base;
    int unsigned     offs[$];
    int unsigned     i;
    int unsigned     j;
    int unsigned     tmp;
    base = gen_model.in_order;
    for (i = one_last ? 2 : 1; i <= k; i++) offs.push_back(i);
    for (i = offs.size(); i > 1; i--) begin
      j = $urandom_range(i - 1);
      tmp = offs[i - 1];
      offs[i - 1] = offs[j];
      offs[j] = tmp;
    end
    if (one_last) offs.push_back(1);
    if ($urandom_range(99) < 20)
      offs.insert($urandom_range(offs.size()), offs[$urandom_range(offs.size() - 1)]);
    foreach (offs[n]) begin
      if ($urandom_range(99) < 8) add_noise();
      add_pkt(base + ID_W'(offs[n]), rand_len(), HANDLE_W'($urandom), 1'b0);
    end
  endfunction

  // packet driver: predicts on accept, then offers the next word or idles
  always @(posedge clk) begin
    if (rst) begin
      pkt_if.valid          <= 1'b0;
      pkt_if.packet_id      <= '0;
      pkt_if.payload_length <= '0;
      pkt_if.buffer_handle  <= '0;
      pkt_if.empty_datagram <= 1'b0;
    end else begin
      if (pkt_if.valid && pkt_if.ready) begin
        receive_packet(rx_model, cur_pkt, 1'b1);
        pkts_taken++;
      end
      if (!pkt_if.valid || pkt_if.ready) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_pkt = pending.pop_front();
          pkt_if.valid          <= 1'b1;
          pkt_if.packet_id      <= cur_pkt.id;
          pkt_if.payload_length <= cur_pkt.len;
          pkt_if.buffer_handle  <= cur_pkt.handle;
          pkt_if.empty_datagram <= cur_pkt.empty;
        end else begin
          pkt_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare against the oldest expected word, random back-pressure
  always @(posedge clk) begin
    res_word_t got;
    res_word_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = '{kind: kind_t'(res_if.kind), ack_number: res_if.ack_number,
                len: res_if.out_length, handle: res_if.out_handle, last: res_if.last};
        words_checked++;
        if (expected_words.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%0t: unexpected word: kind %0d num %0d len %0d handle %h last %b",
                     $realtime, got.kind, got.ack_number, got.len, got.handle, got.last);
        end else begin
          want = expected_words.pop_front();
          if (got.kind !== want.kind || got.ack_number !== want.ack_number ||
              got.len !== want.len || got.handle !== want.handle || got.last !== want.last) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("%0t: word %0d wrong: exp kind %0d num %0d len %0d handle %h last %b",
                       $realtime, words_checked, want.kind, want.ack_number, want.len,
                       want.handle, want.last);
              $display("%0t: word %0d wrong: got kind %0d num %0d len %0d handle %h last %b",
                       $realtime, words_checked, got.kind, got.ack_number, got.len,
                       got.handle, got.last);
            end
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    gen_model = '0;
    rx_model  = '0;

    // directed: out-of-order store, duplicate, length extremes, window edges
    add_pkt(ID_W'(3), '0, '0, 1'b0);
    add_pkt(ID_W'(3), LEN_W'(7), HANDLE_W'(16'haaaa), 1'b0);
    add_pkt(ID_W'(2), LEN_W'(MAX_LEN), '1, 1'b0);
    add_pkt(ID_W'(5), '1, HANDLE_W'(16'h1234), 1'b0);
    add_pkt(ID_W'(32), LEN_W'(100), HANDLE_W'(1), 1'b0);
    add_pkt(ID_W'(33), LEN_W'(9), HANDLE_W'(2), 1'b0);
    add_pkt('1, LEN_W'(1), HANDLE_W'(3), 1'b0);
    // expected packet releases 1..3
    add_pkt(ID_W'(1), LEN_W'(64), HANDLE_W'(16'h8001), 1'b0);
    // stale numbers: equal to the ack and one behind it
    add_pkt(ID_W'(3), LEN_W'(5), HANDLE_W'(4), 1'b0);
    add_pkt(ID_W'(2), LEN_W'(5), HANDLE_W'(5), 1'b0);
    add_pkt(ID_W'(4), LEN_W'(2047), HANDLE_W'(16'h00ff), 1'b0);
    add_pkt(ID_W'(32'h4000_0000), LEN_W'(1), HANDLE_W'(16'h5555), 1'b0);
    add_pkt(ID_W'(32'h2aaa_aaaa), LEN_W'(2), HANDLE_W'(16'h7fff), 1'b0);
    add_pkt(ID_W'(6), LEN_W'(3), HANDLE_W'(6), 1'b0);
    // full window held, then the expected packet walks all of it
    add_burst(WIN, 1'b1);

    // random: mostly well-formed runs, some partial runs, some stray packets
    while (pending.size() < NUM_PKTS) begin
      case ($urandom_range(19) / 2)
        0, 1, 2, 3, 4, 5, 6:
          add_burst(($urandom_range(9) == 0) ? $urandom_range(WIN, 9) : $urandom_range(8, 1),
                    $urandom_range(3) == 0);
        7:
          repeat ($urandom_range(6, 1))
            add_pkt(gen_model.in_order + ID_W'($urandom_range(WIN, 2)), rand_len(),
                    HANDLE_W'($urandom), 1'b0);
        default:
          add_noise();
      endcase
    end

    // close the transfer, then a few packets that must be ignored
    if ($urandom_range(1))
      add_pkt('0, rand_len(), HANDLE_W'($urandom), 1'b0);
    else
      add_pkt(ID_W'($urandom), rand_len(), HANDLE_W'($urandom), 1'b1);
    repeat (4) add_pkt(ID_W'($urandom), rand_len(), HANDLE_W'($urandom), 1'($urandom_range(1)));
    n_total = pending.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // idling phases: none, sender gaps, receiver stalls, both
    while (pkts_taken < n_total / 4) @(posedge clk);
    send_idle_pct = 61;
    while (pkts_taken < n_total / 2) @(posedge clk);
    send_idle_pct = 0;
    stall_pct     = 61;
    while (pkts_taken < 3 * n_total / 4) @(posedge clk);
    send_idle_pct = 14;
    stall_pct     = 14;

    // drain
    while (pending.size() != 0 || pkt_if.valid || expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d packets and %0d result words: %0d acks, %0d delivers, %0d finish",
             pkts_taken, words_checked, n_acks, n_delivers, n_finishes);
    $display("longest in-order release %0d packets, %0d bad words", longest_run, n_errors);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rrca_pkg.sv
rtl/rrca_if.sv
rtl/rrca_mod_unit.sv
rtl/reorder_receiver_cumulative_ack_top.sv
verif/tb_top.sv
